@@ sv/bbuh_pkg.sv @@
// ----------------------------------------------------------------------------
// bbuh_pkg
// Shared types, widths and helpers for the byte-budget undo history.
// ----------------------------------------------------------------------------
package bbuh_pkg;

    localparam int DEPTH    = 64;
    localparam int TAG_BITS = 16;

    localparam int SLOT_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int LIM_W   = (CNT_W > 7) ? CNT_W : 7;

    // port field widths
    localparam int OP_W      = 3;
    localparam int TAG_W     = 16;
    localparam int BYTES_W   = 24;
    localparam int HELD_W    = 30;
    localparam int OCNT_W    = 7;
    localparam int TOTAL_W   = HELD_W + 1;   // room for one entry above the budget
    localparam int IN_BITS   = OP_W + TAG_W + BYTES_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = TAG_W + 3 + OCNT_W + OCNT_W + HELD_W + OCNT_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD   = OUT_W - OUT_BITS;
    localparam int CFG_W     = 30;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_COMMIT = 3'd0,
        OP_UNDO   = 3'd1,
        OP_REDO   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_BYTES = 1'b0,
        REG_MAX_DEPTH = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TAG,
        ST_TRIM,
        ST_TRIM_SUB,
        ST_WRITE,
        ST_EVICT,
        ST_OLD_SUB,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                wen;
        logic [SLOT_W-1:0]   addr;
        logic [TAG_BITS-1:0] tag;
        logic [BYTES_W-1:0]  size;
    } store_wr_t;

    // (base + ofs) mod DEPTH, ofs below DEPTH
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0]  ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(ofs);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

endpackage

@@ sv/bbuh_store.sv @@
// ----------------------------------------------------------------------------
// bbuh_store
// Tag and size ring memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bbuh_store (
    input  logic                          aclk,
    input  bbuh_pkg::store_wr_t           wr,
    input  logic [bbuh_pkg::SLOT_W-1:0]   raddr,
    output logic [bbuh_pkg::TAG_BITS-1:0] rd_tag,
    output logic [bbuh_pkg::BYTES_W-1:0]  rd_size
);
    import bbuh_pkg::*;

    logic [TAG_BITS-1:0] tag_mem  [DEPTH];
    logic [BYTES_W-1:0]  size_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.wen) begin
            tag_mem[wr.addr]  <= wr.tag;
            size_mem[wr.addr] <= wr.size;
        end
        rd_tag  <= tag_mem[raddr];
        rd_size <= size_mem[raddr];
    end

endmodule

@@ sv/byte_budget_undo_history.sv @@
// ----------------------------------------------------------------------------
// byte_budget_undo_history
// Undo/redo history ring with a running byte total and budget eviction.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  s_      | in  | s_tvalid / s_tready       | s_tdata: op, entry_tag, entry_bytes
//  m_      | out | m_tvalid / m_tready       | m_tdata: tag_out .. dropped
//  cfg_    | in  | cfg_wr_en (no back-pressure) | cfg_index, cfg_wdata
//
//  Query, clear or a refused move: decode, then result; undo/redo pass a tag
//  step between them. The result step waits while an earlier beat is stalled.
//  Commit: decode, trim, write, evict, result; a subtract step per entry removed,
//  for the one add/subtract unit on the byte total and the registered size read.
//  One item in flight; s_tready is high only in idle. A finished beat waits in
//  the output register while the next item is taken.
//  Synchronous active-low reset; the ring memory itself is not cleared.
// ----------------------------------------------------------------------------
module byte_budget_undo_history (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] op, [18:3] entry_tag, [42:19] entry_bytes
    input  logic [bbuh_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] tag_out, [16] has_undo, [17] has_redo, [18] error,
    // [25:19] entry_count, [32:26] cursor_pos, [62:33] bytes_held, [69:63] dropped
    output logic [bbuh_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [bbuh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbuh_pkg::CFG_W-1:0]     cfg_wdata
);
    import bbuh_pkg::*;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [TAG_BITS-1:0]  tag_in_reg, tag_in_next;
    logic [BYTES_W-1:0]   bytes_in_reg, bytes_in_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     cursor_reg, cursor_next;
    logic [SLOT_W-1:0]    oldest_reg, oldest_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [OCNT_W-1:0]    dropped_reg, dropped_next;
    logic                 err_reg, err_next;
    logic [TAG_BITS-1:0]  tag_res_reg, tag_res_next;
    logic                 evict_reg, evict_next;
    logic [HELD_W-1:0]    max_bytes_reg, max_bytes_next;
    logic [6:0]           max_depth_reg, max_depth_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]     m_data_reg, m_data_next;

    store_wr_t            wr;
    logic [SLOT_W-1:0]    raddr;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [BYTES_W-1:0]   rd_size;

    // shared add/subtract unit on the byte total
    logic                 alu_sub;
    logic [TOTAL_W-1:0]   alu_opnd;
    logic [TOTAL_W-1:0]   alu_sum;

    logic [LIM_W-1:0]     depth_ext;
    logic [LIM_W-1:0]     lim;
    logic                 over_budget;
    logic                 over_depth;
    logic [OCNT_W-1:0]    drop_inc;
    logic [OCNT_W-1:0]    held_sat;

    bbuh_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .raddr   (raddr),
        .rd_tag  (rd_tag),
        .rd_size (rd_size)
    );

    assign alu_sub  = (state_reg != ST_WRITE);
    assign alu_opnd = alu_sub ? TOTAL_W'(rd_size) : TOTAL_W'(bytes_in_reg);
    assign alu_sum  = alu_sub ? (total_reg - alu_opnd) : (total_reg + alu_opnd);

    assign depth_ext   = LIM_W'(max_depth_reg);
    assign lim         = (depth_ext == '0) ? LIM_W'(1)
                       : ((depth_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : depth_ext);
    assign over_budget = (total_reg >= TOTAL_W'(max_bytes_reg));
    assign over_depth  = (LIM_W'(held_reg) > lim);

    // dropped saturates at all ones
    assign drop_inc = (dropped_reg == '1) ? dropped_reg : dropped_reg + OCNT_W'(1);
    assign held_sat = (LIM_W'(held_reg) > LIM_W'({OCNT_W{1'b1}})) ? {OCNT_W{1'b1}}
                                                                  : OCNT_W'(held_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        tag_in_next    = tag_in_reg;
        bytes_in_next  = bytes_in_reg;
        held_next      = held_reg;
        cursor_next    = cursor_reg;
        oldest_next    = oldest_reg;
        total_next     = total_reg;
        dropped_next   = dropped_reg;
        err_next       = err_reg;
        tag_res_next   = tag_res_reg;
        evict_next     = evict_reg;
        max_bytes_next = max_bytes_reg;
        max_depth_next = max_depth_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        raddr          = oldest_reg;
        wr.wen         = 1'b0;
        wr.addr        = slot_add(oldest_reg, held_reg);
        wr.tag         = tag_in_reg;
        wr.size        = bytes_in_reg;

        if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_MAX_BYTES: max_bytes_next = cfg_wdata[HELD_W-1:0];
                REG_MAX_DEPTH: max_depth_next = cfg_wdata[6:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next       = op_t'(s_tdata[OP_W-1:0]);
                    tag_in_next   = TAG_BITS'(s_tdata[OP_W +: TAG_W]);
                    bytes_in_next = s_tdata[OP_W+TAG_W +: BYTES_W];
                    dropped_next  = '0;
                    err_next      = 1'b0;
                    tag_res_next  = '0;
                    evict_next    = 1'b0;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (op_reg)
                    OP_COMMIT: state_next = ST_TRIM;
                    OP_UNDO: begin
                        if (cursor_reg == '0) begin
                            err_next   = 1'b1;
                            state_next = ST_RESULT;
                        end else begin
                            raddr       = slot_add(oldest_reg, cursor_reg - CNT_W'(1));
                            cursor_next = cursor_reg - CNT_W'(1);
                            state_next  = ST_TAG;
                        end
                    end
                    OP_REDO: begin
                        if (cursor_reg >= held_reg) begin
                            err_next   = 1'b1;
                            state_next = ST_RESULT;
                        end else begin
                            raddr       = slot_add(oldest_reg, cursor_reg);
                            cursor_next = cursor_reg + CNT_W'(1);
                            state_next  = ST_TAG;
                        end
                    end
                    OP_CLEAR: begin
                        dropped_next = held_sat;
                        held_next    = '0;
                        cursor_next  = '0;
                        total_next   = '0;
                        state_next   = ST_RESULT;
                    end
                    default: state_next = ST_RESULT;
                endcase
            end
            ST_TAG: begin
                tag_res_next = rd_tag;
                state_next   = ST_RESULT;
            end
            ST_TRIM: begin
                // redo branch first, newest end; then room for the new entry
                if (held_reg > cursor_reg) begin
                    raddr        = slot_add(oldest_reg, held_reg - CNT_W'(1));
                    held_next    = held_reg - CNT_W'(1);
                    dropped_next = drop_inc;
                    state_next   = ST_TRIM_SUB;
                end else if (held_reg >= CNT_W'(DEPTH)) begin
                    raddr        = oldest_reg;
                    oldest_next  = slot_add(oldest_reg, CNT_W'(1));
                    held_next    = held_reg - CNT_W'(1);
                    cursor_next  = cursor_reg - CNT_W'(1);
                    dropped_next = drop_inc;
                    evict_next   = 1'b0;
                    state_next   = ST_OLD_SUB;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_TRIM_SUB: begin
                total_next = alu_sum;
                state_next = ST_TRIM;
            end
            ST_WRITE: begin
                wr.wen      = 1'b1;
                held_next   = held_reg + CNT_W'(1);
                cursor_next = held_reg + CNT_W'(1);
                total_next  = alu_sum;
                state_next  = ST_EVICT;
            end
            ST_EVICT: begin
                if (cursor_reg != '0 && (over_budget || over_depth)) begin
                    raddr        = oldest_reg;
                    oldest_next  = slot_add(oldest_reg, CNT_W'(1));
                    held_next    = held_reg - CNT_W'(1);
                    cursor_next  = cursor_reg - CNT_W'(1);
                    dropped_next = drop_inc;
                    evict_next   = 1'b1;
                    state_next   = ST_OLD_SUB;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_OLD_SUB: begin
                total_next = alu_sum;
                state_next = evict_reg ? ST_EVICT : ST_WRITE;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{OUT_PAD{1'b0}},
                                    dropped_reg,
                                    HELD_W'(total_reg),
                                    OCNT_W'(cursor_reg),
                                    OCNT_W'(held_reg),
                                    err_reg,
                                    (cursor_reg < held_reg),
                                    (cursor_reg != '0),
                                    TAG_W'(tag_res_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            cursor_reg    <= '0;
            oldest_reg    <= '0;
            total_reg     <= '0;
            max_bytes_reg <= '0;
            max_depth_reg <= 7'd64;
            m_valid_reg   <= 1'b0;
            evict_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            cursor_reg    <= cursor_next;
            oldest_reg    <= oldest_next;
            total_reg     <= total_next;
            max_bytes_reg <= max_bytes_next;
            max_depth_reg <= max_depth_next;
            m_valid_reg   <= m_valid_next;
            evict_reg     <= evict_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        tag_in_reg   <= tag_in_next;
        bytes_in_reg <= bytes_in_next;
        dropped_reg  <= dropped_next;
        err_reg      <= err_next;
        tag_res_reg  <= tag_res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

@@ sv/bbuh_check.sv @@
// ----------------------------------------------------------------------------
// bbuh_check
// Port-level checks on the result channel of the undo history.
// ----------------------------------------------------------------------------
module bbuh_check (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [bbuh_pkg::OUT_W-1:0] m_tdata
);
    import bbuh_pkg::*;

    // a stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // cursor never beyond the entry count
    a_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[32:26] <= m_tdata[25:19]))
        else $error("cursor beyond entry count");

    // availability flags follow cursor and count
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16] == (m_tdata[32:26] != 7'd0)) &&
                     (m_tdata[17] == (m_tdata[32:26] < m_tdata[25:19])))
        else $error("undo/redo flags inconsistent");

    // a refused move reports no tag and removes nothing
    a_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> (m_tdata[15:0] == 16'd0) && (m_tdata[69:63] == 7'd0))
        else $error("error beat carries tag or drops");

endmodule

bind byte_budget_undo_history bbuh_check u_bbuh_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
